[rtl/core/mbrtu_pkg.sv]
// Shared types, constants and the CRC-16/MODBUS byte update for the
// Modbus RTU read-register framer. No dependencies.
`default_nettype none

package mbrtu_pkg;

  typedef enum logic [0:0] {
    KIND_REQUEST = 1'b0,
    KIND_RX_BYTE = 1'b1
  } in_kind_t;

  typedef enum logic [1:0] {
    RK_TX     = 2'd0,
    RK_WORD   = 2'd1,
    RK_STATUS = 2'd2
  } res_kind_t;

  localparam logic [7:0]  FUNC_READ = 8'h03;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [8:0]  RX_DONE   = 9'd260;
  localparam logic [2:0]  TX_LAST   = 3'd7;
  localparam logic [2:0]  TX_CRC_LO = 3'd6;

  // One byte of CRC-16/MODBUS, reflected, eight shift steps.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/core/modbus_rtu_read_register_framer.sv]
// Results are registered: an input transfer that yields a result shows it in the next cycle.
// A request yields eight transmit bytes, one per cycle while the output is not
// stalled; the input is stalled while bytes 0 to 6 are shown.
// A received byte may enter in every cycle while no request bytes are pending and the output is not stalled.
// The frame CRC is built one byte per cycle while the request bytes go out and the output is not stalled.
// Reset (synchronous): output empty, parser at offset 0, response CRC at 0xFFFF.
`default_nettype none

module modbus_rtu_read_register_framer (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_kind,
  input  wire logic [7:0]         in_slave_address,
  input  wire logic [15:0]        in_register_address,
  input  wire logic [15:0]        in_quantity,
  input  wire logic [7:0]         in_rx_byte,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_result_kind,
  output logic [7:0]              out_tx_byte,
  output logic signed [15:0]      out_reg_value,
  output logic [6:0]              out_reg_index,
  output logic                    out_crc_error,
  output logic                    out_last
);
  import mbrtu_pkg::*;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        res_kind_r, res_kind_nxt;
  logic [7:0]        tx_byte_r, tx_byte_nxt;
  logic [15:0]       reg_value_r, reg_value_nxt;
  logic [6:0]        reg_index_r, reg_index_nxt;
  logic              crc_error_r, crc_error_nxt;
  logic              last_r, last_nxt;

  // request sequencer
  logic              tx_active_r, tx_active_nxt;
  logic [2:0]        tx_cnt_r, tx_cnt_nxt;
  logic [15:0]       tx_crc_r, tx_crc_nxt;
  logic [15:0]       req_reg_r, req_reg_nxt;
  logic [15:0]       req_qty_r, req_qty_nxt;

  // response parser
  logic [8:0]        rx_pos_r, rx_pos_nxt;
  logic [7:0]        byte_count_r, byte_count_nxt;
  logic [15:0]       rx_crc_r, rx_crc_nxt;
  logic [7:0]        data_high_r, data_high_nxt;
  logic [6:0]        word_index_r, word_index_nxt;
  logic [7:0]        crc_low_r, crc_low_nxt;

  logic              in_ready, in_xfer, advance;
  logic [2:0]        tx_next;
  logic [7:0]        tx_sel;
  logic [8:0]        pos_off;
  logic              in_data;

  assign in_ready = !out_valid_r || (!out_stall && !(tx_active_r && tx_cnt_r != TX_LAST));
  assign in_stall = !in_ready;
  assign in_xfer  = in_valid && in_ready;
  assign advance  = out_valid_r && !out_stall;

  assign tx_next  = tx_cnt_r + 3'd1;
  assign pos_off  = rx_pos_r - 9'd3;
  assign in_data  = (rx_pos_r < 9'd3) || (pos_off < {1'b0, byte_count_r});

  always_comb begin
    unique case (tx_next)
      3'd1:    tx_sel = FUNC_READ;
      3'd2:    tx_sel = req_reg_r[15:8];
      3'd3:    tx_sel = req_reg_r[7:0];
      3'd4:    tx_sel = req_qty_r[15:8];
      3'd5:    tx_sel = req_qty_r[7:0];
      3'd6:    tx_sel = tx_crc_r[7:0];
      3'd7:    tx_sel = tx_crc_r[15:8];
      default: tx_sel = 8'h00;
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    res_kind_nxt   = res_kind_r;
    tx_byte_nxt    = tx_byte_r;
    reg_value_nxt  = reg_value_r;
    reg_index_nxt  = reg_index_r;
    crc_error_nxt  = crc_error_r;
    last_nxt       = last_r;
    tx_active_nxt  = tx_active_r;
    tx_cnt_nxt     = tx_cnt_r;
    tx_crc_nxt     = tx_crc_r;
    req_reg_nxt    = req_reg_r;
    req_qty_nxt    = req_qty_r;
    rx_pos_nxt     = rx_pos_r;
    byte_count_nxt = byte_count_r;
    rx_crc_nxt     = rx_crc_r;
    data_high_nxt  = data_high_r;
    word_index_nxt = word_index_r;
    crc_low_nxt    = crc_low_r;

    if (in_xfer) begin
      res_kind_nxt  = RK_TX;
      tx_byte_nxt   = 8'h00;
      reg_value_nxt = 16'h0000;
      reg_index_nxt = 7'd0;
      crc_error_nxt = 1'b0;
      last_nxt      = 1'b0;
      if (in_kind == KIND_REQUEST) begin
        // show the address byte now, stream the rest from the sequencer
        out_valid_nxt  = 1'b1;
        tx_byte_nxt    = in_slave_address;
        tx_active_nxt  = 1'b1;
        tx_cnt_nxt     = 3'd0;
        tx_crc_nxt     = crc_byte(CRC_INIT, in_slave_address);
        req_reg_nxt    = in_register_address;
        req_qty_nxt    = in_quantity;
        rx_pos_nxt     = 9'd0;
        byte_count_nxt = 8'h00;
        rx_crc_nxt     = CRC_INIT;
        data_high_nxt  = 8'h00;
        word_index_nxt = 7'd0;
        crc_low_nxt    = 8'h00;
      end else begin
        out_valid_nxt = 1'b0;
        tx_active_nxt = 1'b0;
        if (rx_pos_r >= RX_DONE) begin
          // frame finished: drop the byte
        end else if (in_data) begin
          rx_crc_nxt = crc_byte(rx_crc_r, in_rx_byte);
          rx_pos_nxt = rx_pos_r + 9'd1;
          if (rx_pos_r == 9'd2) begin
            byte_count_nxt = in_rx_byte;
          end else if (rx_pos_r >= 9'd3) begin
            if (!pos_off[0]) begin
              data_high_nxt = in_rx_byte;
            end else begin
              out_valid_nxt  = 1'b1;
              res_kind_nxt   = RK_WORD;
              reg_value_nxt  = {data_high_r, in_rx_byte};
              reg_index_nxt  = word_index_r;
              word_index_nxt = word_index_r + 7'd1;
            end
          end
        end else if (rx_pos_r == 9'd3 + {1'b0, byte_count_r}) begin
          crc_low_nxt = in_rx_byte;
          rx_pos_nxt  = rx_pos_r + 9'd1;
        end else begin
          out_valid_nxt = 1'b1;
          res_kind_nxt  = RK_STATUS;
          crc_error_nxt = ({in_rx_byte, crc_low_r} != rx_crc_r);
          last_nxt      = 1'b1;
          rx_pos_nxt    = RX_DONE;
        end
      end
    end else if (advance) begin
      if (tx_active_r && tx_cnt_r != TX_LAST) begin
        tx_cnt_nxt  = tx_next;
        tx_byte_nxt = tx_sel;
        last_nxt    = (tx_next == TX_LAST);
        // fold header bytes into the CRC until the CRC itself goes out
        if (tx_next < TX_CRC_LO) begin
          tx_crc_nxt = crc_byte(tx_crc_r, tx_sel);
        end
      end else begin
        out_valid_nxt = 1'b0;
        tx_active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      tx_active_r  <= 1'b0;
      tx_cnt_r     <= 3'd0;
      rx_pos_r     <= 9'd0;
      byte_count_r <= 8'h00;
      rx_crc_r     <= CRC_INIT;
      data_high_r  <= 8'h00;
      word_index_r <= 7'd0;
      crc_low_r    <= 8'h00;
    end else begin
      out_valid_r  <= out_valid_nxt;
      tx_active_r  <= tx_active_nxt;
      tx_cnt_r     <= tx_cnt_nxt;
      rx_pos_r     <= rx_pos_nxt;
      byte_count_r <= byte_count_nxt;
      rx_crc_r     <= rx_crc_nxt;
      data_high_r  <= data_high_nxt;
      word_index_r <= word_index_nxt;
      crc_low_r    <= crc_low_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_kind_r  <= res_kind_nxt;
    tx_byte_r   <= tx_byte_nxt;
    reg_value_r <= reg_value_nxt;
    reg_index_r <= reg_index_nxt;
    crc_error_r <= crc_error_nxt;
    last_r      <= last_nxt;
    tx_crc_r    <= tx_crc_nxt;
    req_reg_r   <= req_reg_nxt;
    req_qty_r   <= req_qty_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = res_kind_r;
  assign out_tx_byte     = tx_byte_r;
  assign out_reg_value   = $signed(reg_value_r);
  assign out_reg_index   = reg_index_r;
  assign out_crc_error   = crc_error_r;
  assign out_last        = last_r;

endmodule

`default_nettype wire

[rtl/core/mbrtu_checker.sv]
// Port-level checks for the Modbus RTU read-register framer, bound to the
// top level. Depends on mbrtu_pkg.
`default_nettype none

module mbrtu_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        in_kind,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_result_kind,
  input wire logic [7:0]  out_tx_byte,
  input wire logic        out_last
);
  import mbrtu_pkg::*;

  // a stalled transfer holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_kind)
      && $stable(out_tx_byte) && $stable(out_last))
    else $error("stalled result changed");

  // an accepted request shows its first transmit byte next cycle
  a_req_first: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_kind == KIND_REQUEST |=>
      out_valid && out_result_kind == RK_TX && !out_last)
    else $error("request did not start a frame");

  // input is held off until the final transmit byte
  a_tx_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == RK_TX && !out_last |-> in_stall)
    else $error("input taken mid frame");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == RK_STATUS |-> out_last)
    else $error("status without last");

  a_word_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == RK_WORD |-> !out_last)
    else $error("register word flagged last");

endmodule

bind modbus_rtu_read_register_framer mbrtu_checker u_mbrtu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_kind         (in_kind),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_result_kind (out_result_kind),
  .out_tx_byte     (out_tx_byte),
  .out_last        (out_last)
);

`default_nettype wire

[verif/tb_modbus_rtu_read_register_framer.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the Modbus RTU read-register framer: request frames,
// parsed register words and frame status are predicted and checked per transfer.
// Depends on mbrtu_pkg and rtl/core/modbus_rtu_read_register_framer.sv.
module tb_modbus_rtu_read_register_framer;
  import mbrtu_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int ITEM_TARGET  = 100;

  typedef struct {
    res_kind_t   kind;
    logic [7:0]  tx_byte;
    logic [15:0] reg_value;
    logic [6:0]  reg_index;
    logic        crc_error;
    logic        last;
  } rtu_result_t;

  class rtu_exchange_scoreboard;
    rtu_result_t due_results[$];
    int          parse_pos;
    int          count_field;
    logic [15:0] resp_crc;
    logic [7:0]  pending_hi;
    logic [6:0]  next_word;
    logic [7:0]  crc_lo_rx;
    int          failures;
    int          checked;
    int          words_seen;
    int          status_seen;

    function new();
      restart_parser();
      failures = 0;
      checked = 0;
      words_seen = 0;
      status_seen = 0;
    endfunction

    static function logic [15:0] crc_step(logic [15:0] acc, logic [7:0] data);
      logic [15:0] c;
      c = acc ^ {8'h00, data};
      repeat (8) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
    endfunction

    function void restart_parser();
      parse_pos = 0;
      count_field = 0;
      resp_crc = CRC_INIT;
      pending_hi = 8'h00;
      next_word = 7'd0;
      crc_lo_rx = 8'h00;
    endfunction

    function void push_result(res_kind_t k, logic [7:0] tx, logic [15:0] val,
                              logic [6:0] idx, logic err, logic lst);
      rtu_result_t r;
      r.kind = k;
      r.tx_byte = tx;
      r.reg_value = val;
      r.reg_index = idx;
      r.crc_error = err;
      r.last = lst;
      due_results.push_back(r);
    endfunction

    // Returns 0 when the block drops the item without any effect.
    function bit take_input(in_kind_t k, logic [7:0] addr, logic [15:0] reg_addr,
                            logic [15:0] qty, logic [7:0] b);
      logic [7:0]  frame[8];
      logic [15:0] c;
      if (k == KIND_REQUEST) begin
        frame[0] = addr;
        frame[1] = FUNC_READ;
        frame[2] = reg_addr[15:8];
        frame[3] = reg_addr[7:0];
        frame[4] = qty[15:8];
        frame[5] = qty[7:0];
        c = CRC_INIT;
        for (int i = 0; i < 6; i++) c = crc_step(c, frame[i]);
        frame[6] = c[7:0];
        frame[7] = c[15:8];
        for (int i = 0; i < 8; i++) push_result(RK_TX, frame[i], 16'h0, 7'd0, 1'b0, i == 7);
        restart_parser();
        return 1'b1;
      end
      if (parse_pos >= int'(RX_DONE)) return 1'b0;
      if (parse_pos < 3 || (parse_pos - 3) < count_field) begin
        resp_crc = crc_step(resp_crc, b);
        if (parse_pos == 2) begin
          count_field = b;
        end else if (parse_pos >= 3) begin
          if (((parse_pos - 3) % 2) == 0) begin
            pending_hi = b;
          end else begin
            push_result(RK_WORD, 8'h00, {pending_hi, b}, next_word, 1'b0, 1'b0);
            next_word = next_word + 7'd1;
          end
        end
        parse_pos++;
      end else if (parse_pos == 3 + count_field) begin
        crc_lo_rx = b;
        parse_pos++;
      end else begin
        push_result(RK_STATUS, 8'h00, 16'h0, 7'd0, {b, crc_lo_rx} != resp_crc, 1'b1);
        parse_pos = RX_DONE;
      end
      return 1'b1;
    endfunction

    function void field_cmp(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(logic [1:0] rk, logic [7:0] tx, logic [15:0] val,
                               logic [6:0] idx, logic err, logic lst);
      rtu_result_t want;
      if (due_results.size() == 0) begin
        $error("result transfer with nothing pending: kind %0d tx %0h", rk, tx);
        failures++;
        return;
      end
      want = due_results.pop_front();
      checked++;
      if (want.kind == RK_WORD) words_seen++;
      if (want.kind == RK_STATUS) status_seen++;
      field_cmp("result_kind", 16'(want.kind), 16'(rk));
      field_cmp("tx_byte", 16'(want.tx_byte), 16'(tx));
      field_cmp("reg_value", want.reg_value, val);
      field_cmp("reg_index", 16'(want.reg_index), 16'(idx));
      field_cmp("crc_error", 16'(want.crc_error), 16'(err));
      field_cmp("last", 16'(want.last), 16'(lst));
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_kind;
  logic [7:0]         in_slave_address;
  logic [15:0]        in_register_address;
  logic [15:0]        in_quantity;
  logic [7:0]         in_rx_byte;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_result_kind;
  logic [7:0]         out_tx_byte;
  logic signed [15:0] out_reg_value;
  logic [6:0]         out_reg_index;
  logic               out_crc_error;
  logic               out_last;

  rtu_exchange_scoreboard book = new();
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;
  bit          counting = 1'b0;
  int          counted_items = 0;
  int          n_requests = 0;
  int          n_rx_bytes = 0;
  int unsigned cycle_count = 0;

  modbus_rtu_read_register_framer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_slave_address    (in_slave_address),
    .in_register_address (in_register_address),
    .in_quantity         (in_quantity),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result_kind     (out_result_kind),
    .out_tx_byte         (out_tx_byte),
    .out_reg_value       (out_reg_value),
    .out_reg_index       (out_reg_index),
    .out_crc_error       (out_crc_error),
    .out_last            (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("modbus_rtu_read_register_framer verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      book.check_result(out_result_kind, out_tx_byte, out_reg_value, out_reg_index,
                        out_crc_error, out_last);
    end
  end

  // Result side: draw a stall length for every result, with calm stretches.
  initial begin : result_backpressure
    int hold;
    forever begin
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      hold = out_calm ? 0 : $urandom_range(0, 10);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid));
    end
  end

  task automatic drive_item(in_kind_t k, logic [7:0] addr, logic [15:0] reg_addr,
                            logic [15:0] qty, logic [7:0] b);
    int gap;
    if ($urandom_range(0, 29) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_slave_address <= addr;
    in_register_address <= reg_addr;
    in_quantity <= qty;
    in_rx_byte <= b;
    // hold the payload until the transfer completes
    do @(posedge clk); while (in_stall);
    if (book.take_input(k, addr, reg_addr, qty, b) && counting) counted_items++;
    if (k == KIND_REQUEST) n_requests++;
    else n_rx_bytes++;
  endtask

  task automatic send_request(logic [7:0] addr, logic [15:0] reg_addr, logic [15:0] qty);
    drive_item(KIND_REQUEST, addr, reg_addr, qty, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_random_request();
    send_request(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)));
  endtask

  task automatic send_byte(logic [7:0] b);
    drive_item(KIND_RX_BYTE, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)), b);
  endtask

  // Build a response frame; fill < 0 means random data, keep < 0 sends it all.
  task automatic send_response(int count, int fill, bit bad_crc, int keep);
    logic [7:0]  frame_bytes[$];
    logic [15:0] c;
    int          stop;
    int          idx;
    frame_bytes.push_back(8'($urandom_range(0, 255)));
    frame_bytes.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : FUNC_READ);
    frame_bytes.push_back(8'(count));
    for (int i = 0; i < count; i++) begin
      frame_bytes.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
    end
    c = CRC_INIT;
    foreach (frame_bytes[i]) c = rtu_exchange_scoreboard::crc_step(c, frame_bytes[i]);
    frame_bytes.push_back(c[7:0]);
    frame_bytes.push_back(c[15:8]);
    if (bad_crc) begin
      idx = frame_bytes.size() - 1 - $urandom_range(0, 1);
      frame_bytes[idx] = frame_bytes[idx] ^ 8'(1 << $urandom_range(0, 7));
    end
    stop = (keep < 0) ? frame_bytes.size() : keep;
    for (int i = 0; i < stop; i++) send_byte(frame_bytes[i]);
  endtask

  initial begin : stimulus
    int pick;
    int count;
    int n;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_kind <= KIND_REQUEST;
    in_slave_address <= 8'h00;
    in_register_address <= 16'h0000;
    in_quantity <= 16'h0000;
    in_rx_byte <= 8'h00;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    counting = 1'b1;

    // parser is live out of reset: a response with no request still parses
    send_response(2, 8'hFF, 1'b0, -1);
    send_byte(8'h00);
    send_request(8'h00, 16'h0000, 16'h0000);
    send_request(8'hFF, 16'hFFFF, 16'hFFFF);
    // odd byte count: trailing data byte gives no word; CRC corrupted
    send_response(3, 8'h00, 1'b1, -1);
    send_random_request();
    // cut the response short, then restart with a new request
    send_response(6, -1, 1'b0, 4);
    send_request(8'h11, 16'h1234, 16'h0002);

    while (counted_items < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if ($urandom_range(0, 4) != 0) send_random_request();
        count = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
        send_response(count, -1, $urandom_range(0, 3) == 0, -1);
        if ($urandom_range(0, 4) == 0) send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 85) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          if ($urandom_range(0, 2) == 0) send_random_request();
          else send_byte(8'($urandom_range(0, 255)));
        end
      end else begin
        count = $urandom_range(2, 12);
        send_random_request();
        send_response(count, -1, 1'b0, $urandom_range(1, count + 4));
        send_random_request();
      end
    end
    counting = 1'b0;
    in_valid <= 1'b0;

    while (book.due_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Drove %0d requests and %0d response bytes over %0d cycles.",
             n_requests, n_rx_bytes, cycle_count);
    $display("Checked %0d results: %0d register words, %0d frame status.",
             book.checked, book.words_seen, book.status_seen);
    if (book.failures == 0) begin
      $display("modbus_rtu_read_register_framer verification clean");
    end else begin
      $display("modbus_rtu_read_register_framer verification failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/mbrtu_pkg.sv
rtl/core/modbus_rtu_read_register_framer.sv
rtl/core/mbrtu_checker.sv
verif/tb_modbus_rtu_read_register_framer.sv
